// ===== rtl/core/polyphonic_voice_allocator_assert.svh =====
// assertion macros for the polyphonic voice allocator
// included by polyphonic_voice_allocator.sv, no other dependencies
`ifndef POLYPHONIC_VOICE_ALLOCATOR_ASSERT_SVH
`define POLYPHONIC_VOICE_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define PVA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("voice allocator check failed");

// next-cycle implication
`define PVA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("voice allocator check failed");

`endif

// ===== rtl/core/pva_pkg.sv =====
// types and constants of the polyphonic voice allocator
// no dependencies
`timescale 1ns / 1ps

package pva_pkg;

    typedef enum logic [1:0] {
        MODE_NOTE_ON     = 2'd0,
        MODE_NOTE_OFF    = 2'd1,
        MODE_TICK        = 2'd2,
        MODE_RELEASE_ALL = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  track;
        logic [6:0]  pitch;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  slot;
        logic        flag;
        logic [4:0]  active_count;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  track;
        logic [6:0]  pitch;
        logic [31:0] age;
        logic [15:0] rel_count;
    } voice_rec_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_OUT
    } state_t;

    localparam logic [15:0] RELEASE_RESET = 16'd132;
    localparam logic [31:0] AGE_MAX       = 32'hFFFF_FFFF;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

endpackage

// ===== rtl/core/polyphonic_voice_allocator.sv =====
// polyphonic voice allocator, oldest-voice stealing, voice records in one memory
// depends on pva_pkg and polyphonic_voice_allocator_assert.svh
`timescale 1ns / 1ps
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------
//  in      | input     | in_valid/in_stall  | in_data  (pva_pkg::in_item_t)
//  out     | output    | out_valid/out_stall| out_data (pva_pkg::out_item_t)
//  cfg     | input     | cfg_valid/cfg_ready| cfg_data (release length)
//
//  an item goes from ST_IDLE through ST_SCAN to ST_OUT, a note on also through ST_FINISH;
//  the voice memory is scanned one entry per cycle
//  reset clears the active and releasing bits, no memory clearing pass is needed
//  a new item is taken while the previous result still waits in the output register
//  a stalled output holds the finished item in its last state until taken

module polyphonic_voice_allocator #(
    parameter int VOICE_COUNT = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  pva_pkg::in_item_t    in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output pva_pkg::out_item_t   out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [15:0]          cfg_data
);

    localparam int IW = $clog2(VOICE_COUNT);
    localparam int CW = $clog2(VOICE_COUNT + 1);
    localparam logic [CW-1:0] LAST = CW'(VOICE_COUNT);

    pva_pkg::state_t      state_reg, state_next;
    pva_pkg::in_item_t    item_reg, item_next;
    logic [CW-1:0]        scan_cnt_reg, scan_cnt_next;
    logic                 proc_valid_reg, proc_valid_next;
    logic [IW-1:0]        proc_idx_reg, proc_idx_next;
    logic [VOICE_COUNT-1:0] active_reg, active_next;
    logic [VOICE_COUNT-1:0] releasing_reg, releasing_next;
    logic                 found_reg, found_next;
    logic [IW-1:0]        pick_reg, pick_next;
    logic [31:0]          oldest_reg, oldest_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 out_valid_reg, out_valid_next;
    pva_pkg::out_item_t   out_data_reg, out_data_next;
    logic [15:0]          release_length_reg;

    pva_pkg::voice_rec_t  voice_mem [VOICE_COUNT];
    pva_pkg::voice_rec_t  rd_data_reg;
    pva_pkg::voice_rec_t  wr_rec;
    logic                 rd_en;
    logic [IW-1:0]        rd_addr;
    logic                 mem_we;
    logic [IW-1:0]        mem_waddr;
    logic                 act;
    logic                 rel;
    logic                 act_after;
    logic [IW+3:0]        slot_ext;
    logic [CW+4:0]        count_ext;

    assign in_stall  = (state_reg != pva_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    assign rd_addr   = scan_cnt_reg[IW-1:0];
    assign rd_en     = (state_reg == pva_pkg::ST_SCAN) && (scan_cnt_reg != LAST);
    assign act       = active_reg[proc_idx_reg];
    assign rel       = releasing_reg[proc_idx_reg];
    assign slot_ext  = {4'b0000, pick_reg};
    assign count_ext = {5'b00000, count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= pva_pkg::ST_IDLE;
            scan_cnt_reg       <= '0;
            proc_valid_reg     <= 1'b0;
            active_reg         <= '0;
            releasing_reg      <= '0;
            found_reg          <= 1'b0;
            count_reg          <= '0;
            out_valid_reg      <= 1'b0;
            release_length_reg <= pva_pkg::RELEASE_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            scan_cnt_reg   <= scan_cnt_next;
            proc_valid_reg <= proc_valid_next;
            active_reg     <= active_next;
            releasing_reg  <= releasing_next;
            found_reg      <= found_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                release_length_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        proc_idx_reg <= proc_idx_next;
        pick_reg     <= pick_next;
        oldest_reg   <= oldest_next;
        out_data_reg <= out_data_next;
    end

    // voice record memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            voice_mem[mem_waddr] <= wr_rec;
        end
        if (rd_en)
        begin
            rd_data_reg <= voice_mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        scan_cnt_next   = scan_cnt_reg;
        proc_valid_next = proc_valid_reg;
        proc_idx_next   = proc_idx_reg;
        active_next     = active_reg;
        releasing_next  = releasing_reg;
        found_next      = found_reg;
        pick_next       = pick_reg;
        oldest_next     = oldest_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = proc_idx_reg;
        wr_rec          = rd_data_reg;
        act_after       = act;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            pva_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next       = in_data;
                    state_next      = pva_pkg::ST_SCAN;
                    scan_cnt_next   = '0;
                    proc_valid_next = 1'b0;
                    found_next      = 1'b0;
                    pick_next       = '0;
                    oldest_next     = '0;
                    count_next      = '0;
                end
            end
            pva_pkg::ST_SCAN:
            begin
                if (scan_cnt_reg != LAST)
                begin
                    proc_valid_next = 1'b1;
                    proc_idx_next   = rd_addr;
                    scan_cnt_next   = scan_cnt_reg + 1'b1;
                end
                else
                begin
                    proc_valid_next = 1'b0;
                    if (item_reg.mode == pva_pkg::MODE_NOTE_ON)
                    begin
                        state_next = pva_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = pva_pkg::ST_OUT;
                    end
                end

                if (proc_valid_reg)
                begin
                    unique case (item_reg.mode)
                        pva_pkg::MODE_NOTE_ON:
                        begin
                            if (!found_reg)
                            begin
                                if (!act)
                                begin
                                    found_next = 1'b1;
                                    pick_next  = proc_idx_reg;
                                end
                                else if (rd_data_reg.age >= oldest_reg)
                                begin
                                    oldest_next = rd_data_reg.age;
                                    pick_next   = proc_idx_reg;
                                end
                            end
                        end
                        pva_pkg::MODE_NOTE_OFF:
                        begin
                            if (!found_reg && act && !rel &&
                                rd_data_reg.track == item_reg.track &&
                                rd_data_reg.pitch == item_reg.pitch)
                            begin
                                found_next                   = 1'b1;
                                pick_next                    = proc_idx_reg;
                                releasing_next[proc_idx_reg] = 1'b1;
                                wr_rec.rel_count             = '0;
                                mem_we                       = 1'b1;
                            end
                        end
                        pva_pkg::MODE_TICK:
                        begin
                            if (act)
                            begin
                                if (rd_data_reg.age != pva_pkg::AGE_MAX)
                                begin
                                    wr_rec.age = rd_data_reg.age + 32'd1;
                                end
                                if (rel)
                                begin
                                    if (rd_data_reg.rel_count != pva_pkg::COUNT_MAX)
                                    begin
                                        wr_rec.rel_count = rd_data_reg.rel_count + 16'd1;
                                    end
                                    if (wr_rec.rel_count >= release_length_reg)
                                    begin
                                        act_after = 1'b0;
                                    end
                                end
                                active_next[proc_idx_reg] = act_after;
                                mem_we                    = 1'b1;
                            end
                        end
                        pva_pkg::MODE_RELEASE_ALL:
                        begin
                            if (act && !rel)
                            begin
                                releasing_next[proc_idx_reg] = 1'b1;
                                wr_rec.rel_count             = '0;
                                mem_we                       = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    count_next = count_reg + CW'(act_after);
                end
            end
            pva_pkg::ST_FINISH:
            begin
                // free voice found, or the oldest one is taken over
                mem_we                   = 1'b1;
                mem_waddr                = pick_reg;
                wr_rec.track             = item_reg.track;
                wr_rec.pitch             = item_reg.pitch;
                wr_rec.age               = '0;
                wr_rec.rel_count         = '0;
                active_next[pick_reg]    = 1'b1;
                releasing_next[pick_reg] = 1'b0;
                count_next               = count_reg + CW'(found_reg);
                state_next               = pva_pkg::ST_OUT;
            end
            pva_pkg::ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.active_count = count_ext[4:0];
                    out_data_next.slot         = '0;
                    out_data_next.flag         = 1'b0;
                    if (item_reg.mode == pva_pkg::MODE_NOTE_ON)
                    begin
                        out_data_next.slot = slot_ext[3:0];
                        out_data_next.flag = !found_reg;
                    end
                    else if (item_reg.mode == pva_pkg::MODE_NOTE_OFF)
                    begin
                        out_data_next.slot = slot_ext[3:0];
                        out_data_next.flag = found_reg;
                    end
                    state_next = pva_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pva_pkg::ST_IDLE;
            end
        endcase
    end

`include "polyphonic_voice_allocator_assert.svh"

    `PVA_ASSERT_NOW(a_count_range, clk, rst_n, 1'b1, count_reg <= LAST)
    `PVA_ASSERT_NOW(a_steal_when_full, clk, rst_n, (state_reg == pva_pkg::ST_FINISH) && !found_reg, &active_reg)
    `PVA_ASSERT_NEXT(a_scan_start, clk, rst_n, in_valid && !in_stall, (state_reg == pva_pkg::ST_SCAN) && (scan_cnt_reg == '0))
    `PVA_ASSERT_NOW(a_no_write_idle, clk, rst_n, (state_reg == pva_pkg::ST_IDLE) || (state_reg == pva_pkg::ST_OUT), !mem_we)

endmodule

// ===== verif/testbench.sv =====
// testbench for the polyphonic voice allocator: directed table, then random phases
// predicts untyped results with its own voice pool model, depends on pva_pkg and the rtl
`timescale 1ns / 1ps

module testbench;

    localparam int NUM_VOICES      = 16;
    localparam int ITEMS_PER_PHASE = 279;
    localparam int QUIET_LIMIT     = 5000;
    localparam int SETTLE_CYCLES   = 2 * (NUM_VOICES + 4);
    localparam int LONG_HOLD       = 700;

    typedef struct {
        bit                 cfg_write;
        logic [15:0]        cfg_value;
        pva_pkg::in_item_t  item;
        bit                 typed;
        pva_pkg::out_item_t result;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] track;
        logic [6:0] pitch;
    } note_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    pva_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_stall;
    pva_pkg::out_item_t out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [15:0]        cfg_data;

    // voice pool model
    logic        v_active    [NUM_VOICES];
    logic        v_releasing [NUM_VOICES];
    logic [7:0]  v_track     [NUM_VOICES];
    logic [6:0]  v_pitch     [NUM_VOICES];
    logic [31:0] v_age       [NUM_VOICES];
    logic [15:0] v_rel_count [NUM_VOICES];
    logic [15:0] release_len;

    pva_pkg::out_item_t pending_results[$];
    note_t              played_notes[$];
    int                 errors;
    int                 burst_left;
    int                 quiet_cycles;

    polyphonic_voice_allocator #(
        .VOICE_COUNT(NUM_VOICES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic pva_pkg::out_item_t next_voice_result(input pva_pkg::in_item_t item);
        pva_pkg::out_item_t res;
        int                 i;
        int                 pick;
        int                 oldest_idx;
        logic [31:0]        oldest;
        int                 n;
        res        = '0;
        pick       = -1;
        oldest_idx = 0;
        oldest     = '0;
        n          = 0;
        case (item.mode)
            pva_pkg::MODE_NOTE_ON:
            begin
                for (i = 0; i < NUM_VOICES; i++)
                begin
                    if (pick < 0)
                    begin
                        if (!v_active[i])
                            pick = i;
                        else if (v_age[i] >= oldest)
                        begin
                            oldest     = v_age[i];
                            oldest_idx = i;
                        end
                    end
                end
                if (pick < 0)
                begin
                    pick     = oldest_idx;
                    res.flag = 1'b1;
                end
                v_active[pick]    = 1'b1;
                v_releasing[pick] = 1'b0;
                v_track[pick]     = item.track;
                v_pitch[pick]     = item.pitch;
                v_age[pick]       = '0;
                v_rel_count[pick] = '0;
                res.slot          = 4'(pick);
            end
            pva_pkg::MODE_NOTE_OFF:
            begin
                for (i = 0; i < NUM_VOICES; i++)
                begin
                    if (!res.flag && v_active[i] && !v_releasing[i]
                        && v_track[i] == item.track && v_pitch[i] == item.pitch)
                    begin
                        v_releasing[i] = 1'b1;
                        v_rel_count[i] = '0;
                        res.slot       = 4'(i);
                        res.flag       = 1'b1;
                    end
                end
            end
            pva_pkg::MODE_TICK:
            begin
                for (i = 0; i < NUM_VOICES; i++)
                begin
                    if (v_active[i])
                    begin
                        if (v_age[i] != pva_pkg::AGE_MAX)
                            v_age[i] = v_age[i] + 32'd1;
                        if (v_releasing[i])
                        begin
                            if (v_rel_count[i] != pva_pkg::COUNT_MAX)
                                v_rel_count[i] = v_rel_count[i] + 16'd1;
                            if (v_rel_count[i] >= release_len)
                                v_active[i] = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
                for (i = 0; i < NUM_VOICES; i++)
                begin
                    if (v_active[i] && !v_releasing[i])
                    begin
                        v_releasing[i] = 1'b1;
                        v_rel_count[i] = '0;
                    end
                end
            end
        endcase
        for (i = 0; i < NUM_VOICES; i++)
            if (v_active[i])
                n++;
        res.active_count = 5'(n);
        return res;
    endfunction

    function automatic stim_row_t ev(input pva_pkg::mode_t m, input logic [7:0] t,
                                     input logic [6:0] p, input bit typed = 1'b0,
                                     input logic [3:0] s = '0, input logic f = 1'b0,
                                     input logic [4:0] n = '0);
        stim_row_t row;
        row.cfg_write    = 1'b0;
        row.cfg_value    = '0;
        row.item.mode    = m;
        row.item.track   = t;
        row.item.pitch   = p;
        row.typed        = typed;
        row.result.slot  = s;
        row.result.flag  = f;
        row.result.active_count = n;
        return row;
    endfunction

    function automatic pva_pkg::in_item_t random_voice_event();
        pva_pkg::in_item_t item;
        int                sel;
        int                k;
        item.track = 8'($urandom);
        item.pitch = 7'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 38)
        begin
            item.mode = pva_pkg::MODE_NOTE_ON;
            // narrow pool so that duplicate notes pile up
            if ($urandom_range(0, 1) == 0)
            begin
                item.track = 8'($urandom_range(0, 3));
                item.pitch = 7'($urandom_range(60, 63));
            end
        end
        else if (sel < 68)
        begin
            item.mode = pva_pkg::MODE_NOTE_OFF;
            if (played_notes.size() > 0 && $urandom_range(0, 9) < 7)
            begin
                k = $urandom_range(0, played_notes.size() - 1);
                item.track = played_notes[k].track;
                item.pitch = played_notes[k].pitch;
            end
        end
        else if (sel < 95)
            item.mode = pva_pkg::MODE_TICK;
        else
            item.mode = pva_pkg::MODE_RELEASE_ALL;
        return item;
    endfunction

    // caller stands at a rising edge
    task automatic offer(input pva_pkg::in_item_t item, input bit typed,
                         input pva_pkg::out_item_t given);
        pva_pkg::out_item_t predicted;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = next_voice_result(item);
        pending_results.push_back(typed ? given : predicted);
        if (item.mode == pva_pkg::MODE_NOTE_ON)
        begin
            played_notes.push_back('{item.track, item.pitch});
            if (played_notes.size() > 24)
                void'(played_notes.pop_front());
        end
    endtask

    task automatic set_release_length(input logic [15:0] value);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        release_len  = value;
        burst_left   = 0;
    endtask

    always @(posedge clk)
    begin : result_check
        pva_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no expected result");
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.slot !== want.slot)
                begin
                    $error("slot: expected %0d, actual %0d", want.slot, out_data.slot);
                    errors++;
                end
                if (out_data.flag !== want.flag)
                begin
                    $error("flag: expected %0d, actual %0d", want.flag, out_data.flag);
                    errors++;
                end
                if (out_data.active_count !== want.active_count)
                begin
                    $error("active_count: expected %0d, actual %0d",
                           want.active_count, out_data.active_count);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : receiver
        int cyc;
        int kind;
        int run;
        bit held;
        cyc       = 0;
        held      = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            kind = $urandom_range(0, 3);
            run  = (kind == 3) ? $urandom_range(1, 10) : $urandom_range(8, 120);
            repeat (run)
            begin
                @(posedge clk);
                cyc++;
                // one long hold-off while items keep coming
                if (!held && cyc >= 5000 && in_valid)
                begin
                    held = 1'b1;
                    out_stall <= 1'b1;
                    repeat (LONG_HOLD) @(posedge clk);
                    cyc += LONG_HOLD;
                end
                if (kind == 0)
                    out_stall <= 1'b0;
                else if (kind == 3)
                    out_stall <= 1'b1;
                else
                    out_stall <= ($urandom_range(0, 2) == 0);
            end
        end
    end

    initial
    begin
        stim_row_t   rows[$];
        logic [15:0] phase_lengths [7];
        int          i;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        burst_left   = 0;
        release_len  = pva_pkg::RELEASE_RESET;
        for (i = 0; i < NUM_VOICES; i++)
        begin
            v_active[i]    = 1'b0;
            v_releasing[i] = 1'b0;
            v_track[i]     = '0;
            v_pitch[i]     = '0;
            v_age[i]       = '0;
            v_rel_count[i] = '0;
        end

        rows.push_back(ev(pva_pkg::MODE_NOTE_OFF, 8'hFF, 7'h7F, 1'b1, 4'd0, 1'b0, 5'd0));
        rows.push_back(ev(pva_pkg::MODE_NOTE_ON,  8'h00, 7'h00, 1'b1, 4'd0, 1'b0, 5'd1));
        rows.push_back(ev(pva_pkg::MODE_NOTE_ON,  8'hFF, 7'h7F, 1'b1, 4'd1, 1'b0, 5'd2));
        rows.push_back(ev(pva_pkg::MODE_NOTE_ON,  8'hFF, 7'h7F, 1'b1, 4'd2, 1'b0, 5'd3));
        rows.push_back(ev(pva_pkg::MODE_NOTE_OFF, 8'hFF, 7'h7F, 1'b1, 4'd1, 1'b1, 5'd3));
        rows.push_back(ev(pva_pkg::MODE_NOTE_OFF, 8'hFF, 7'h7F, 1'b1, 4'd2, 1'b1, 5'd3));
        rows.push_back(ev(pva_pkg::MODE_NOTE_OFF, 8'hFF, 7'h7F, 1'b1, 4'd0, 1'b0, 5'd3));
        rows.push_back('{1'b1, 16'd0, '0, 1'b0, '0});
        rows.push_back(ev(pva_pkg::MODE_TICK, 8'hA5, 7'h5A, 1'b1, 4'd0, 1'b0, 5'd1));
        for (i = 1; i < NUM_VOICES; i++)
            rows.push_back(ev(pva_pkg::MODE_NOTE_ON, 8'(i * 17), 7'(i * 9)));
        // full pool: oldest voice goes first, then a tie goes to the top index
        rows.push_back(ev(pva_pkg::MODE_NOTE_ON, 8'h3C, 7'h3C, 1'b1, 4'd0, 1'b1, 5'd16));
        rows.push_back(ev(pva_pkg::MODE_NOTE_ON, 8'hC3, 7'h43, 1'b1, 4'd15, 1'b1, 5'd16));
        rows.push_back(ev(pva_pkg::MODE_RELEASE_ALL, 8'h00, 7'h00, 1'b1, 4'd0, 1'b0, 5'd16));
        rows.push_back(ev(pva_pkg::MODE_TICK, 8'h00, 7'h00, 1'b1, 4'd0, 1'b0, 5'd0));

        phase_lengths = '{16'd132, 16'hFFFF, 16'd1, 16'd4, 16'd0, 16'd0, 16'd24};
        phase_lengths[4] = 16'($urandom_range(2, 12));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[r])
        begin
            if (rows[r].cfg_write)
                set_release_length(rows[r].cfg_value);
            else
                offer(rows[r].item, rows[r].typed, rows[r].result);
        end

        foreach (phase_lengths[p])
        begin
            set_release_length(phase_lengths[p]);
            repeat (ITEMS_PER_PHASE)
                offer(random_voice_event(), 1'b0, '0);
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== polyphonic_voice_allocator.f =====
+incdir+rtl/core
rtl/core/pva_pkg.sv
rtl/core/polyphonic_voice_allocator.sv
verif/testbench.sv
